// ----- src/b64d_pkg.sv -----
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'
    localparam logic [7:0] DASH_CHAR  = 8'h2D;  // '-'
    localparam logic [7:0] UNDER_CHAR = 8'h5F;  // '_'
    localparam logic [5:0] SEXTET_62  = 6'd62;
    localparam logic [5:0] SEXTET_63  = 6'd63;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
    } out_item_t;

    // One decoded group: up to three bytes, oldest in the top, and how many to send.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
    } group_t;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == PLUS_CHAR || c == DASH_CHAR)
        begin
            v = SEXTET_62;
        end
        else if (c == SLASH_CHAR || c == UNDER_CHAR)
        begin
            v = SEXTET_63;
        end
        return v;
    endfunction

endpackage

// ----- src/b64d_front.sv -----
module b64d_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  b64d_pkg::in_item_t in_item,
    input  logic               q_full,
    output logic               q_push,
    output b64d_pkg::group_t   q_group
);

    logic [1:0]  pos_reg,       pos_next;
    logic [17:0] held_reg,      held_next;
    logic        third_pad_reg, third_pad_next;
    logic        stopped_reg,   stopped_next;

    logic        accept;
    logic [5:0]  sx;
    logic        pad;
    logic [17:0] held_shift;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign sx         = b64d_pkg::sextet_of(in_item.char_byte);
    assign pad        = (in_item.char_byte == b64d_pkg::PAD_CHAR);
    assign held_shift = {held_reg[11:0], sx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            held_reg      <= 18'd0;
            third_pad_reg <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            third_pad_reg <= third_pad_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        held_next      = held_reg;
        third_pad_next = third_pad_reg;
        stopped_next   = stopped_reg;
        q_push         = 1'b0;
        q_group        = '0;
        if (accept)
        begin
            if (stopped_reg)
            begin
                // drop everything after a padded group until the end beat
                if (in_item.end_of_input)
                begin
                    stopped_next = 1'b0;
                end
            end
            else if (pos_reg == 2'd3)
            begin
                q_push         = 1'b1;
                q_group.bits   = {held_reg, sx};
                q_group.count  = third_pad_reg ? 2'd1 : (pad ? 2'd2 : 2'd3);
                pos_next       = 2'd0;
                held_next      = 18'd0;
                third_pad_next = 1'b0;
                stopped_next   = (third_pad_reg || pad) && !in_item.end_of_input;
            end
            else
            begin
                held_next = held_shift;
                pos_next  = pos_reg + 2'd1;
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = pad;
                end
                if (in_item.end_of_input)
                begin
                    // flush the partial group as if padded
                    q_push = 1'b1;
                    case (pos_reg)
                        2'd0:
                        begin
                            q_group.bits  = {held_shift[5:0], 18'd0};
                            q_group.count = 2'd1;
                        end
                        2'd1:
                        begin
                            q_group.bits  = {held_shift[11:0], 12'd0};
                            q_group.count = 2'd1;
                        end
                        default:
                        begin
                            q_group.bits  = {held_shift, 6'd0};
                            q_group.count = pad ? 2'd1 : 2'd2;
                        end
                    endcase
                    pos_next       = 2'd0;
                    held_next      = 18'd0;
                    third_pad_next = 1'b0;
                    stopped_next   = 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.end_of_input |=> pos_reg == 2'd0 && !stopped_reg && !third_pad_reg)
        else $error("state not cleared after end beat");

    a_stopped_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> pos_reg == 2'd0)
        else $error("stopped with a partial group held");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_group.count != 2'd0 && !q_full)
        else $error("bad push into group queue");
`endif

endmodule

// ----- src/b64d_queue.sv -----
module b64d_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64d_pkg::group_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output b64d_pkg::group_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::group_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/b64d_back.sv -----
module b64d_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64d_pkg::group_t    q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output b64d_pkg::out_item_t out_item
);

    logic                work_valid_reg, work_valid_next;
    logic [23:0]         work_bits_reg,  work_bits_next;
    logic [1:0]          work_left_reg,  work_left_next;
    logic                out_valid_reg,  out_valid_next;
    b64d_pkg::out_item_t out_item_reg,   out_item_next;

    logic advance;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign advance   = work_valid_reg && (!out_valid_reg || !out_stall);
    assign q_pop     = q_valid && (!work_valid_reg || (advance && work_left_reg == 2'd1));

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        work_valid_next = work_valid_reg;
        work_bits_next  = work_bits_reg;
        work_left_next  = work_left_reg;
        if (advance)
        begin
            out_valid_next            = 1'b1;
            out_item_next.data_byte   = work_bits_reg[23:16];
            out_item_next.last_of_run = (work_left_reg == 2'd1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            work_valid_next = 1'b1;
            work_bits_next  = q_data.bits;
            work_left_next  = q_data.count;
        end
        else if (advance)
        begin
            work_bits_next  = {work_bits_reg[15:0], 8'd0};
            work_left_next  = work_left_reg - 2'd1;
            work_valid_next = (work_left_reg != 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_left_reg  <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            work_left_reg  <= work_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_bits_reg <= work_bits_next;
        out_item_reg  <= out_item_next;
    end

`ifndef SYNTHESIS
    a_work_left: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> work_left_reg != 2'd0)
        else $error("active group with no bytes left");
`endif

endmodule

// ----- src/base64_stream_decoder_unit.sv -----
// A finished group is written into the group queue, then loaded into the byte sender's
// work register; its first byte is then registered onto out_valid. Characters are taken
// one per cycle unless the queue is full; bytes go out one per cycle while out_stall is low.
// in_stall rises only while the group queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, asynchronous) empties the queue and output register and clears group state.
module base64_stream_decoder_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  b64d_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output b64d_pkg::out_item_t out_item
);

    // Front end: map each character to a sextet, gather groups of four and
    // push a finished group (or a flushed partial one at the end beat).
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_not_empty;
    b64d_pkg::group_t q_push_data;
    b64d_pkg::group_t q_pop_data;

    b64d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_group  (q_push_data)
    );

    // Short queue of decoded groups: lets the character side keep going while
    // the byte side is held by out_stall.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // Back end: send one byte per beat, marking the last byte of each group.
    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ----- test/base64_stream_decoder_unit_test.sv -----
module base64_stream_decoder_unit_test;

    // Longest legal wait on either side of the block, in cycles.
    localparam int MAX_WAIT      = 16;
    // Cycles with no beat on either channel before the run is abandoned.
    localparam int IDLE_LIMIT    = 2000;
    // Cycles to watch the output after the last expected byte, for strays.
    localparam int SETTLE_CYCLES = 8;
    // Gathered characters wanted from the random part.
    localparam int RANDOM_CHARS  = 64;

    // Tracks the decoder state, works out the bytes each character beat should
    // produce and checks output beats against them in order.
    class decoded_byte_tracker;

        logic [1:0]          chars_held;
        logic [17:0]         sextets;
        bit                  third_pad;
        bit                  after_pad;
        b64d_pkg::out_item_t bytes_due[$];
        int                  faults;
        int                  bytes_checked;

        function new();
            clear();
            faults        = 0;
            bytes_checked = 0;
        endfunction

        function void clear();
            chars_held = 2'd0;
            sextets    = 18'd0;
            third_pad  = 1'b0;
            after_pad  = 1'b0;
        endfunction

        function logic [5:0] char_value(input logic [7:0] ch);
            if (ch >= "A" && ch <= "Z")
            begin
                return 6'(ch - "A");
            end
            if (ch >= "a" && ch <= "z")
            begin
                return 6'(ch - "a" + 26);
            end
            if (ch >= "0" && ch <= "9")
            begin
                return 6'(ch - "0" + 52);
            end
            if (ch == b64d_pkg::PLUS_CHAR || ch == b64d_pkg::DASH_CHAR)
            begin
                return b64d_pkg::SEXTET_62;
            end
            if (ch == b64d_pkg::SLASH_CHAR || ch == b64d_pkg::UNDER_CHAR)
            begin
                return b64d_pkg::SEXTET_63;
            end
            return 6'd0;
        endfunction

        function void queue_bytes(input logic [5:0] a, input logic [5:0] b,
                                  input logic [5:0] c, input logic [5:0] d, input int count);
            logic [23:0]         packed_bits;
            b64d_pkg::out_item_t one;
            packed_bits = {a, b, c, d};
            for (int k = 0; k < count; k++)
            begin
                one.data_byte   = packed_bits[23 - 8 * k -: 8];
                one.last_of_run = (k == count - 1);
                bytes_due.push_back(one);
            end
        endfunction

        // Note one accepted character beat. Returns 1 if the decoder takes it into a
        // group, 0 if it is dropped because a padded group has already been seen.
        function int take_char(input b64d_pkg::in_item_t beat);
            logic [5:0] v;
            bit         pad;
            v   = char_value(beat.char_byte);
            pad = (beat.char_byte == b64d_pkg::PAD_CHAR);
            if (after_pad)
            begin
                if (beat.end_of_input)
                begin
                    clear();
                end
                return 0;
            end
            if (chars_held == 2'd3)
            begin
                queue_bytes(sextets[17:12], sextets[11:6], sextets[5:0], v,
                            third_pad ? 1 : (pad ? 2 : 3));
                chars_held = 2'd0;
                sextets    = 18'd0;
                after_pad  = third_pad || pad;
                third_pad  = 1'b0;
                if (beat.end_of_input)
                begin
                    clear();
                end
                return 1;
            end
            sextets = {sextets[11:0], v};
            if (chars_held == 2'd2)
            begin
                third_pad = pad;
            end
            chars_held = chars_held + 2'd1;
            if (beat.end_of_input)
            begin
                case (chars_held)
                    2'd1:    queue_bytes(sextets[5:0], 6'd0, 6'd0, 6'd0, 1);
                    2'd2:    queue_bytes(sextets[11:6], sextets[5:0], 6'd0, 6'd0, 1);
                    default: queue_bytes(sextets[17:12], sextets[11:6], sextets[5:0], 6'd0,
                                         third_pad ? 1 : 2);
                endcase
                clear();
            end
            return 1;
        endfunction

        // Check one accepted output beat against the oldest byte still due.
        function void match_byte(input b64d_pkg::out_item_t got);
            b64d_pkg::out_item_t want;
            if (bytes_due.size() == 0)
            begin
                $error("unexpected byte %02h (last_of_run %0b) with nothing due",
                       got.data_byte, got.last_of_run);
                faults++;
                return;
            end
            want = bytes_due.pop_front();
            bytes_checked++;
            if (got.data_byte !== want.data_byte)
            begin
                $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
                faults++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
                faults++;
            end
        endfunction

    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    b64d_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    b64d_pkg::out_item_t out_item;

    decoded_byte_tracker ledger;

    // Quiet spells: while set, that side never idles or stalls.
    bit send_quiet;
    bit recv_quiet;
    int idle_cycles;
    int chars_sent;
    int chars_gathered;
    int messages_sent;

    base64_stream_decoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Draw a wait for one beat: half the time none, otherwise anywhere up to the maximum.
    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Send one character beat. Called just after a rising edge; returns at the edge
    // that accepted the beat, with valid still high.
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{char_byte: ch, end_of_input: last};
        // Hold the beat until the decoder stops stalling.
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        chars_sent++;
        chars_gathered += ledger.take_char(in_item);
        if ($urandom_range(0, 40) == 0)
        begin
            send_quiet = !send_quiet;
        end
    endtask

    // Send a string, raising the end flag on its final character if asked.
    task automatic send_text(input string text, input bit end_last);
        int i;
        for (i = 0; i < text.len(); i++)
        begin
            send_char(text[i], end_last && (i == text.len() - 1));
        end
    endtask

    // Drop valid and hold off until every byte due has been accepted.
    task automatic drain_bytes();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (ledger.bytes_due.size() != 0);
    endtask

    // Any character of either alphabet, url-safe ones included.
    function automatic logic [7:0] random_symbol();
        int k;
        k = $urandom_range(0, 65);
        if (k < 26)
        begin
            return 8'("A" + k);
        end
        if (k < 52)
        begin
            return 8'("a" + k - 26);
        end
        if (k < 62)
        begin
            return 8'("0" + k - 52);
        end
        case (k)
            62:      return b64d_pkg::PLUS_CHAR;
            63:      return b64d_pkg::SLASH_CHAR;
            64:      return b64d_pkg::DASH_CHAR;
            default: return b64d_pkg::UNDER_CHAR;
        endcase
    endfunction

    // One message: mostly well-formed groups with random content and one of the
    // possible endings, sometimes plain noise of arbitrary bytes and end flags.
    task automatic send_message();
        b64d_pkg::in_item_t msg[$];
        int                 kind;
        int                 groups;
        int                 tail;
        int                 i;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            groups = $urandom_range(0, 3);
            tail   = $urandom_range(0, 4);
            if ((tail == 0 || tail == 4) && groups == 0)
            begin
                groups = 1;
            end
            for (i = 0; i < 4 * groups; i++)
            begin
                msg.push_back('{char_byte: random_symbol(), end_of_input: 1'b0});
            end
            case (tail)
                1, 2:
                begin
                    // Padded group: two symbols and two pads, or three and one, then
                    // some characters the decoder should drop, then the end beat.
                    for (i = 0; i < tail + 1; i++)
                    begin
                        msg.push_back('{char_byte: random_symbol(), end_of_input: 1'b0});
                    end
                    for (i = 0; i < 3 - tail; i++)
                    begin
                        msg.push_back('{char_byte: b64d_pkg::PAD_CHAR, end_of_input: 1'b0});
                    end
                    for (i = $urandom_range(0, 2); i > 0; i--)
                    begin
                        msg.push_back('{char_byte: 8'($urandom_range(0, 255)),
                                        end_of_input: 1'b0});
                    end
                    msg.push_back('{char_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
                end
                3:
                begin
                    // End inside a group, with no pad.
                    for (i = $urandom_range(1, 3); i > 0; i--)
                    begin
                        msg.push_back('{char_byte: random_symbol(), end_of_input: 1'b0});
                    end
                end
                default:
                begin
                end
            endcase
            if (tail == 0 || tail == 3)
            begin
                msg[msg.size() - 1].end_of_input = 1'b1;
            end
        end
        else
        begin
            for (i = $urandom_range(1, 8); i > 0; i--)
            begin
                msg.push_back('{char_byte: 8'($urandom_range(0, 255)),
                                end_of_input: ($urandom_range(0, 4) == 0)});
            end
        end
        foreach (msg[j])
        begin
            send_char(msg[j].char_byte, msg[j].end_of_input);
        end
        messages_sent++;
    endtask

    // Receiver: before each byte, stall for a drawn number of cycles, then take it.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = draw_wait(recv_quiet);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            ledger.match_byte(out_item);
            if ($urandom_range(0, 31) == 0)
            begin
                recv_quiet = !recv_quiet;
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int random_start;
        ledger         = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_stall      = 1'b0;
        send_quiet     = 1'b0;
        recv_quiet     = 1'b0;
        idle_cycles    = 0;
        chars_sent     = 0;
        chars_gathered = 0;
        messages_sent  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: alphabet extremes, both symbol pairs, full group with the
        // end flag on its fourth character.
        send_text("Az09", 1'b0);
        send_text("+/-_", 1'b1);
        // Pad in the third place: one byte, then drop characters until the end beat.
        send_text("TQ==x", 1'b0);
        send_char("?", 1'b1);
        // Pad only in the fourth place, arriving with the end flag.
        send_text("TWE=", 1'b1);
        // End inside a group after one, two and three characters, the last with
        // a pad in the third place; bytes outside the alphabet decode as zero.
        send_char("Z", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        send_text("a/M", 1'b1);
        send_text("ab=", 1'b1);
        messages_sent += 7;

        // Hold the sender off until the decoder has emptied out.
        drain_bytes();

        random_start = chars_gathered;
        while (chars_gathered - random_start < RANDOM_CHARS)
        begin
            send_message();
        end
        // Close any open group so its bytes come out.
        send_char(random_symbol(), 1'b1);

        drain_bytes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d character beats in %0d messages, %0d taken into groups",
                 chars_sent, messages_sent, chars_gathered);
        $display("checked %0d decoded bytes, %0d faults", ledger.bytes_checked, ledger.faults);
        if (ledger.faults == 0 && ledger.bytes_due.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
